// File: rtl/hec_pkg.sv
// ----------------------------------------------------------------------------
// hec_pkg
// Shared types, field widths and defaults for the Huffman code emitter/packer.
// ----------------------------------------------------------------------------
package hec_pkg;

  // Input item field widths.
  localparam int CMD_W        = 2;
  localparam int SYM_FIELD_W  = 8;
  localparam int LEN_FIELD_W  = 6;
  localparam int CODE_FIELD_W = 32;

  // Output item field widths.
  localparam int BYTE_W = 8;

  // A code of at most 32 bits plus up to 7 held bits completes at most 4 bytes.
  localparam int MAX_BYTES = 4;
  localparam int MAX_BYTES_W = 3;
  localparam int HELD_W = 3;

  // Parameter defaults.
  localparam int DEF_MAX_CODE_LEN = 32;
  localparam int DEF_SYMBOL_COUNT = 256;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

  // Stored code length is capped by the configured maximum and by the code field.
  function automatic int len_cap(input int max_code_len);
    len_cap = (max_code_len < CODE_FIELD_W) ? max_code_len : CODE_FIELD_W;
  endfunction

endpackage

// File: rtl/hec_if.sv
// ----------------------------------------------------------------------------
// hec_in_if / hec_out_if
// Valid/ready channels for command items and for packed output bytes.
// ----------------------------------------------------------------------------
interface hec_in_if;
  logic                               valid;
  logic                               ready;
  logic [hec_pkg::CMD_W-1:0]          command;
  logic [hec_pkg::SYM_FIELD_W-1:0]    symbol;
  logic [hec_pkg::LEN_FIELD_W-1:0]    code_length;
  logic [hec_pkg::CODE_FIELD_W-1:0]   code_bits;

  modport source (output valid, command, symbol, code_length, code_bits, input ready);
  modport sink   (input valid, command, symbol, code_length, code_bits, output ready);
endinterface

interface hec_out_if;
  logic                          valid;
  logic                          ready;
  logic [hec_pkg::BYTE_W-1:0]    packed_byte;
  logic                          last_of_run;

  modport source (output valid, packed_byte, last_of_run, input ready);
  modport sink   (input valid, packed_byte, last_of_run, output ready);
endinterface

// File: rtl/hec_code_table.sv
// ----------------------------------------------------------------------------
// hec_code_table
// Per-symbol code storage with registered read and resettable valid bits.
// ----------------------------------------------------------------------------
module hec_code_table #(
  parameter int MAX_CODE_LEN = hec_pkg::DEF_MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = hec_pkg::DEF_SYMBOL_COUNT
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    wr_req,
  input  logic                                    rd_req,
  input  logic [hec_pkg::SYM_FIELD_W-1:0]         symbol,
  input  logic [hec_pkg::LEN_FIELD_W-1:0]         code_length,
  input  logic [hec_pkg::CODE_FIELD_W-1:0]        code_bits,
  output logic                                    rd_hit,
  output logic [$clog2(hec_pkg::len_cap(MAX_CODE_LEN)+1)-1:0] rd_len,
  output logic [hec_pkg::len_cap(MAX_CODE_LEN)-1:0] rd_code
);

  localparam int LEN_CAP = hec_pkg::len_cap(MAX_CODE_LEN);
  localparam int LEN_W   = $clog2(LEN_CAP + 1);
  localparam int SYM_W   = $clog2(SYMBOL_COUNT);
  localparam int WORD_W  = LEN_W + LEN_CAP;

  logic [WORD_W-1:0]                  mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0]            valid_r;
  logic [WORD_W-1:0]                  rd_word_r;
  logic                               rd_hit_r;
  logic                               in_range;
  logic [SYM_W-1:0]                   idx;
  logic [hec_pkg::LEN_FIELD_W-1:0]    sat_len;

  assign in_range = {1'b0, symbol} < (hec_pkg::SYM_FIELD_W + 1)'(SYMBOL_COUNT);
  assign idx      = symbol[SYM_W-1:0];

  // Over-long codes saturate to the largest supported length.
  assign sat_len = (code_length > hec_pkg::LEN_FIELD_W'(LEN_CAP)) ?
                   hec_pkg::LEN_FIELD_W'(LEN_CAP) : code_length;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_req && in_range) begin
      valid_r[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_req && in_range) begin
      mem[idx] <= {LEN_W'(sat_len), code_bits[LEN_CAP-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req) begin
      rd_hit_r <= in_range ? valid_r[idx] : 1'b0;
      if (in_range) begin
        rd_word_r <= mem[idx];
      end
    end
  end

  assign rd_hit  = rd_hit_r;
  assign rd_len  = rd_word_r[WORD_W-1 -: LEN_W];
  assign rd_code = rd_word_r[LEN_CAP-1:0];

endmodule

// File: rtl/huffman_code_emitter_packer_core.sv
// ----------------------------------------------------------------------------
// huffman_code_emitter_packer_core
// Huffman encoder back end: code table lookup and MSB-first byte packing.
// ----------------------------------------------------------------------------
// Load commands write a symbol's code into the table; encode commands look the
// symbol up and append its code, first bit first, to the bit accumulator, and
// every completed byte leaves with the earliest bit in bit 7; flush pads the
// partial byte with zeros and sends it. An accepted item waits in the table
// read stage until the output buffer has drained or is sending its last byte,
// then loads the buffer with the bytes it makes (none for loads, misses and
// empty flushes): the single output port sends one byte per cycle while
// out_ch.ready is high. The first byte of an item reaches the output through
// the table read stage register and then the output buffer register. Table
// valid bits clear at reset.
module huffman_code_emitter_packer_core #(
  parameter int MAX_CODE_LEN = hec_pkg::DEF_MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = hec_pkg::DEF_SYMBOL_COUNT
) (
  input  logic      clk,
  input  logic      rst_n,
  hec_in_if.sink    in_ch,
  hec_out_if.source out_ch
);

  localparam int LEN_CAP = hec_pkg::len_cap(MAX_CODE_LEN);
  localparam int LEN_W   = $clog2(LEN_CAP + 1);
  localparam int BW      = hec_pkg::BYTE_W;
  localparam int WIN_W   = BW + hec_pkg::CODE_FIELD_W;
  localparam int NWIN    = hec_pkg::MAX_BYTES + 1;

  logic                                s1_valid_r;
  hec_pkg::cmd_t                       s1_cmd_r;
  logic                                accept;
  logic                                s1_adv;
  logic                                obuf_free;
  logic                                pop;

  logic                                rd_hit;
  logic [LEN_W-1:0]                    rd_len;
  logic [LEN_CAP-1:0]                  rd_code;

  logic [BW-1:0]                       acc_r, acc_nxt;
  logic [hec_pkg::HELD_W-1:0]          held_r, held_nxt;
  logic [BW-1:0]                       buf_r [hec_pkg::MAX_BYTES];
  logic [BW-1:0]                       buf_nxt [hec_pkg::MAX_BYTES];
  logic [hec_pkg::MAX_BYTES_W-1:0]     rem_r, rem_nxt;

  logic [hec_pkg::LEN_FIELD_W-1:0]     len6;
  logic [hec_pkg::LEN_FIELD_W-1:0]     total;
  logic [hec_pkg::MAX_BYTES_W-1:0]     nbytes;
  logic [hec_pkg::CODE_FIELD_W-1:0]    code_la;
  logic [WIN_W-1:0]                    win;
  logic [BW-1:0]                       win_byte [NWIN];

  // Handshake. The stage-1 item moves on once the output buffer drains.
  assign pop       = out_ch.valid && out_ch.ready;
  assign obuf_free = (rem_r == '0) ||
                     ((rem_r == hec_pkg::MAX_BYTES_W'(1)) && out_ch.ready);
  assign s1_adv    = s1_valid_r && obuf_free;
  assign in_ch.ready = !s1_valid_r || obuf_free;
  assign accept    = in_ch.valid && in_ch.ready;

  hec_code_table #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_req      (accept && (in_ch.command == hec_pkg::CMD_LOAD)),
    .rd_req      (accept && (in_ch.command == hec_pkg::CMD_ENCODE)),
    .symbol      (in_ch.symbol),
    .code_length (in_ch.code_length),
    .code_bits   (in_ch.code_bits),
    .rd_hit      (rd_hit),
    .rd_len      (rd_len),
    .rd_code     (rd_code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r <= hec_pkg::cmd_t'(in_ch.command);
    end
  end

  // The accumulator is kept left-aligned, so the held bits sit at the top and
  // the code is placed directly below them in a 40-bit window.
  assign len6    = hec_pkg::LEN_FIELD_W'(rd_len);
  assign code_la = hec_pkg::CODE_FIELD_W'(rd_code) <<
                   (hec_pkg::LEN_FIELD_W'(hec_pkg::CODE_FIELD_W) - len6);
  assign win     = {acc_r, {hec_pkg::CODE_FIELD_W{1'b0}}} | ({code_la, {BW{1'b0}}} >> held_r);
  assign total   = hec_pkg::LEN_FIELD_W'(held_r) + len6;
  assign nbytes  = total[hec_pkg::LEN_FIELD_W-1:hec_pkg::HELD_W];

  always_comb begin
    for (int k = 0; k < NWIN; k++) begin
      win_byte[k] = win[WIN_W-1-BW*k -: BW];
    end
  end

  always_comb begin
    acc_nxt  = acc_r;
    held_nxt = held_r;
    rem_nxt  = rem_r;
    for (int k = 0; k < hec_pkg::MAX_BYTES; k++) begin
      buf_nxt[k] = buf_r[k];
    end

    if (pop) begin
      rem_nxt = rem_r - hec_pkg::MAX_BYTES_W'(1);
      for (int k = 0; k < hec_pkg::MAX_BYTES - 1; k++) begin
        buf_nxt[k] = buf_r[k+1];
      end
    end

    if (s1_adv) begin
      case (s1_cmd_r)
        hec_pkg::CMD_ENCODE: begin
          if (rd_hit) begin
            rem_nxt  = nbytes;
            held_nxt = total[hec_pkg::HELD_W-1:0];
            for (int k = 0; k < hec_pkg::MAX_BYTES; k++) begin
              buf_nxt[k] = win_byte[k];
            end
            // The partial byte left over is the window byte just past the last full one.
            case (nbytes)
              3'd0:    acc_nxt = win_byte[0];
              3'd1:    acc_nxt = win_byte[1];
              3'd2:    acc_nxt = win_byte[2];
              3'd3:    acc_nxt = win_byte[3];
              default: acc_nxt = win_byte[4];
            endcase
          end
        end
        hec_pkg::CMD_FLUSH: begin
          if (held_r != '0) begin
            rem_nxt    = hec_pkg::MAX_BYTES_W'(1);
            buf_nxt[0] = acc_r;
            acc_nxt    = '0;
            held_nxt   = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      held_r <= '0;
      rem_r  <= '0;
    end else begin
      acc_r  <= acc_nxt;
      held_r <= held_nxt;
      rem_r  <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < hec_pkg::MAX_BYTES; k++) begin
      buf_r[k] <= buf_nxt[k];
    end
  end

  assign out_ch.valid       = (rem_r != '0);
  assign out_ch.packed_byte = buf_r[0];
  assign out_ch.last_of_run = (rem_r == hec_pkg::MAX_BYTES_W'(1));

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the Huffman code emitter/packer core.
// ----------------------------------------------------------------------------
// Loads, encodes, flushes and unused commands go through the input channel.
// Each accepted command updates a local copy of the code table and the bit
// packer, which yields the bytes the core should send. Every output transfer
// is checked in order against them. Both channels idle at random, with some
// calm stretches and with pauses that let the output drain completely.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_CODE_LEN = hec_pkg::DEF_MAX_CODE_LEN;
  localparam int SYMBOL_COUNT = hec_pkg::DEF_SYMBOL_COUNT;
  localparam int LEN_LIMIT    = (MAX_CODE_LEN < hec_pkg::CODE_FIELD_W) ?
                                MAX_CODE_LEN : hec_pkg::CODE_FIELD_W;
  localparam logic [hec_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 120;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [hec_pkg::CMD_W-1:0]        command;
    logic [hec_pkg::SYM_FIELD_W-1:0]  symbol;
    logic [hec_pkg::LEN_FIELD_W-1:0]  code_length;
    logic [hec_pkg::CODE_FIELD_W-1:0] code_bits;
    int                               idle_before;
    bit                               drain_first;
    bit                               calm;
  } cmd_item_t;

  typedef struct {
    logic [hec_pkg::BYTE_W-1:0] packed_byte;
    logic                       last_of_run;
  } packed_out_t;

  logic clk;
  logic rst_n;

  hec_in_if  in_ch ();
  hec_out_if out_ch ();

  huffman_code_emitter_packer_core #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Local copy of the code table and the packer.
  logic [hec_pkg::LEN_FIELD_W-1:0]  code_len_tab [SYMBOL_COUNT];
  logic [hec_pkg::CODE_FIELD_W-1:0] code_val_tab [SYMBOL_COUNT];
  bit                               code_ok_tab  [SYMBOL_COUNT];
  logic [7:0]                       pack_acc;
  int unsigned                      pack_held;

  cmd_item_t   pending_items[$];
  packed_out_t expected_bytes[$];
  cmd_item_t   cur_item;
  int          idle_left;
  int          stall_left;
  int          quiet_cycles;
  int          error_count;
  bit          calm_phase;
  bit          stim_calm;

  always #5 clk = ~clk;

  // Applies one accepted command to the local state and queues its bytes.
  function automatic void predict_packed_bytes(input cmd_item_t it);
    logic [7:0] made [4];
    int         made_count;
    int         i;
    int unsigned n;
    made_count = 0;
    if (it.command == hec_pkg::CMD_LOAD) begin
      if (it.symbol < SYMBOL_COUNT) begin
        code_len_tab[it.symbol] = (it.code_length > LEN_LIMIT) ?
                                  hec_pkg::LEN_FIELD_W'(LEN_LIMIT) : it.code_length;
        code_val_tab[it.symbol] = it.code_bits;
        code_ok_tab[it.symbol]  = 1'b1;
      end
    end else if (it.command == hec_pkg::CMD_ENCODE) begin
      if (it.symbol < SYMBOL_COUNT && code_ok_tab[it.symbol]) begin
        n = code_len_tab[it.symbol];
        for (i = int'(n) - 1; i >= 0; i--) begin
          pack_acc = {pack_acc[6:0], code_val_tab[it.symbol][i]};
          pack_held++;
          if (pack_held == 8) begin
            if (made_count < hec_pkg::MAX_BYTES) begin
              made[made_count] = pack_acc;
              made_count++;
            end
            pack_acc  = '0;
            pack_held = 0;
          end
        end
      end
    end else if (it.command == hec_pkg::CMD_FLUSH) begin
      if (pack_held > 0) begin
        made[0]    = pack_acc << (8 - pack_held);
        made_count = 1;
        pack_acc   = '0;
        pack_held  = 0;
      end
    end
    for (i = 0; i < made_count; i++) begin
      expected_bytes.push_back('{packed_byte: made[i], last_of_run: (i == made_count - 1)});
    end
  endfunction

  task automatic queue_cmd(input logic [hec_pkg::CMD_W-1:0] cmd, input logic [7:0] sym,
                           input logic [5:0] len, input logic [31:0] bits,
                           input bit drain);
    cmd_item_t it;
    it.command     = cmd;
    it.symbol      = sym;
    it.code_length = len;
    it.code_bits   = bits;
    it.idle_before = stim_calm ? 0 : $urandom_range(0, 10);
    it.drain_first = drain;
    it.calm        = stim_calm;
    pending_items.push_back(it);
  endtask

  // Input driver: waits out each item's gap, then presents it until transfer.
  always @(posedge clk) begin
    bit busy;
    busy = in_ch.valid;
    if (!rst_n) begin
      busy      = 1'b0;
      idle_left = -1;
    end else begin
      if (busy && in_ch.ready) begin
        predict_packed_bytes(cur_item);
        busy = 1'b0;
      end
      if (!busy && pending_items.size() != 0) begin
        if (idle_left < 0) idle_left = pending_items[0].idle_before;
        if (pending_items[0].drain_first && expected_bytes.size() != 0) begin
          // Hold off until the output side has caught up completely.
        end else if (idle_left > 0) begin
          idle_left--;
        end else begin
          cur_item = pending_items.pop_front();
          in_ch.command     <= cur_item.command;
          in_ch.symbol      <= cur_item.symbol;
          in_ch.code_length <= cur_item.code_length;
          in_ch.code_bits   <= cur_item.code_bits;
          calm_phase        <= cur_item.calm;
          busy      = 1'b1;
          idle_left = -1;
        end
      end
    end
    in_ch.valid <= busy;
  end

  // Output monitor: checks each transfer and stalls ready at random after it.
  always @(posedge clk) begin
    logic        rdy;
    packed_out_t want;
    rdy = out_ch.ready;
    if (!rst_n) begin
      rdy        = 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte %02h last %0b", $time, out_ch.packed_byte,
                   out_ch.last_of_run);
          error_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_ch.packed_byte !== want.packed_byte) begin
            $display("%0t: packed_byte expected %02h actual %02h", $time,
                     want.packed_byte, out_ch.packed_byte);
            error_count++;
          end
          if (out_ch.last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run expected %0b actual %0b", $time,
                     want.last_of_run, out_ch.last_of_run);
            error_count++;
          end
        end
        stall_left = calm_phase ? 0 : $urandom_range(0, 10);
        rdy = (stall_left == 0);
      end else if (!rdy) begin
        if (stall_left > 0) stall_left--;
        if (stall_left == 0) rdy = 1'b1;
      end
    end
    out_ch.ready <= rdy;
  end

  // Watchdog on cycles without any transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bit         loaded [SYMBOL_COUNT];
    logic [7:0] loaded_list[$];
    logic [7:0] sym;
    logic [5:0] len;
    int         counted;
    int         pick;

    clk               = 1'b0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.command     = hec_pkg::CMD_LOAD;
    in_ch.symbol      = '0;
    in_ch.code_length = '0;
    in_ch.code_bits   = '0;
    out_ch.ready      = 1'b0;
    pack_acc          = '0;
    pack_held         = 0;
    error_count       = 0;
    quiet_cycles      = 0;
    calm_phase        = 1'b0;
    stim_calm         = 1'b0;
    for (int i = 0; i < SYMBOL_COUNT; i++) begin
      code_ok_tab[i] = 1'b0;
      loaded[i]      = 1'b0;
    end

    // Directed part: misses, empty flush, unused command, zero and
    // oversized lengths, a four-byte code and partial-byte flushes.
    queue_cmd(hec_pkg::CMD_ENCODE, 8'd5, 6'd0, $urandom(), 1'b0);
    queue_cmd(hec_pkg::CMD_FLUSH, 8'd0, 6'd0, 32'd0, 1'b0);
    queue_cmd(CMD_UNUSED, 8'hff, 6'h3f, 32'hffff_ffff, 1'b0);
    queue_cmd(hec_pkg::CMD_LOAD, 8'd0, 6'd0, 32'hffff_ffff, 1'b0);
    queue_cmd(hec_pkg::CMD_ENCODE, 8'd0, 6'd0, 32'd0, 1'b0);
    queue_cmd(hec_pkg::CMD_LOAD, 8'd255, 6'd63, 32'ha5a5_5a5a, 1'b0);
    queue_cmd(hec_pkg::CMD_LOAD, 8'd1, 6'd32, 32'd0, 1'b0);
    queue_cmd(hec_pkg::CMD_LOAD, 8'd2, 6'd1, 32'd1, 1'b0);
    queue_cmd(hec_pkg::CMD_LOAD, 8'd3, 6'd7, 32'h0000_0055, 1'b0);
    queue_cmd(hec_pkg::CMD_LOAD, 8'd4, 6'd33, 32'h8000_0001, 1'b0);
    queue_cmd(hec_pkg::CMD_LOAD, 8'd6, 6'd3, 32'hffff_fffd, 1'b0);
    queue_cmd(hec_pkg::CMD_ENCODE, 8'd255, 6'd0, 32'd0, 1'b0);
    queue_cmd(hec_pkg::CMD_ENCODE, 8'd2, 6'h3f, 32'hffff_ffff, 1'b0);
    queue_cmd(hec_pkg::CMD_ENCODE, 8'd255, 6'd0, 32'd0, 1'b0);
    queue_cmd(hec_pkg::CMD_ENCODE, 8'd3, 6'd0, 32'd0, 1'b0);
    queue_cmd(hec_pkg::CMD_FLUSH, 8'd0, 6'd0, 32'd0, 1'b1);
    queue_cmd(hec_pkg::CMD_ENCODE, 8'd6, 6'd0, 32'd0, 1'b0);
    queue_cmd(hec_pkg::CMD_FLUSH, 8'hff, 6'h3f, 32'hffff_ffff, 1'b0);
    queue_cmd(hec_pkg::CMD_ENCODE, 8'd4, 6'd0, 32'd0, 1'b0);
    queue_cmd(hec_pkg::CMD_ENCODE, 8'd6, 6'd0, 32'd0, 1'b0);
    queue_cmd(hec_pkg::CMD_ENCODE, 8'd1, 6'd0, 32'd0, 1'b0);
    queue_cmd(hec_pkg::CMD_FLUSH, 8'd0, 6'd0, 32'd0, 1'b0);
    queue_cmd(CMD_UNUSED, 8'd0, 6'd0, 32'd0, 1'b1);
    foreach (loaded_list[i]) loaded_list.delete(i);
    loaded_list = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd3, 8'd4, 8'd6};
    foreach (loaded_list[i]) loaded[loaded_list[i]] = 1'b1;

    // Random part: mostly encodes of loaded symbols, with new loads,
    // flushes, misses and unused commands mixed in.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 30 == 0) stim_calm = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        sym = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom());
        case ($urandom_range(0, 9))
          0:       len = 6'd0;
          7, 8:    len = 6'($urandom_range(13, 32));
          9:       len = 6'($urandom_range(33, 63));
          default: len = 6'($urandom_range(1, 12));
        endcase
        if (!loaded[sym]) loaded_list.push_back(sym);
        loaded[sym] = 1'b1;
        queue_cmd(hec_pkg::CMD_LOAD, sym, len, $urandom(), 1'b0);
        counted++;
      end else if (pick < 80) begin
        if (loaded_list.size() != 0 && $urandom_range(0, 9) < 8)
          sym = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        else
          sym = 8'($urandom());
        queue_cmd(hec_pkg::CMD_ENCODE, sym, 6'($urandom()), $urandom(), counted == 75);
        counted++;
      end else if (pick < 94) begin
        queue_cmd(hec_pkg::CMD_FLUSH, 8'($urandom()), 6'($urandom()), $urandom(), 1'b0);
        counted++;
      end else begin
        // The core ignores this one, so it does not count toward the total.
        queue_cmd(CMD_UNUSED, 8'($urandom()), 6'($urandom()), $urandom(), 1'b0);
      end
    end
    queue_cmd(hec_pkg::CMD_FLUSH, 8'd0, 6'd0, 32'd0, 1'b0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_ch.valid || expected_bytes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
